// ===== sv/md5_stream_hasher_core_assert.svh =====
// ----------------------------------------------------------------------------
// md5_stream_hasher_core_assert.svh
// Assertion macros shared by the checker of the MD5 stream hasher.
// ----------------------------------------------------------------------------
`ifndef MD5_STREAM_HASHER_CORE_ASSERT_SVH
`define MD5_STREAM_HASHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MD5SH_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("md5sh checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is high.
`define MD5SH_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("md5sh checker: next-cycle property failed");

`endif

// ===== sv/md5sh_pkg.sv =====
// ----------------------------------------------------------------------------
// md5sh_pkg
// Types, constants and small functions shared by the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5sh_pkg;

   typedef logic [3:0][31:0] word4_type;

   typedef enum logic [1:0] {
      BUF_IDLE,
      BUF_DATA,
      BUF_PAD,
      BUF_CLEAR
   } buf_op_type;

   // Write request for the message block buffer.
   typedef struct packed {
      buf_op_type  op;
      logic [5:0]  fill;
      logic [2:0]  cnt;
      logic [31:0] data;
      logic        len_en;
      logic [63:0] len_bits;
   } buf_ctrl_type;

   // Control of the shared round unit.
   typedef struct packed {
      logic       load;
      logic       run;
      logic       accum;
      logic       init;
      logic [5:0] rnd;
      logic [5:0] kw_rnd;
   } rnd_ctrl_type;

   localparam logic [5:0] LEN_POS = 6'd56;
   localparam logic [2:0] MAX_BYTES = 3'd4;

   localparam word4_type CHAIN_INIT = {
      32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   localparam logic [31:0] K_TABLE [64] = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
      32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
      32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
      32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
      32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
      32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
      32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
      32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
      32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
      32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
      32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
      32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
      32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
      32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
      32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
   };

   // Message word used by a round.
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] lo;
      logic [3:0] idx;
      lo = rnd[3:0];
      case (rnd[5:4])
         2'd0:    idx = lo;
         2'd1:    idx = (lo << 2) + lo + 4'd1;
         2'd2:    idx = (lo << 1) + lo + 4'd5;
         2'd3:    idx = (lo << 3) - lo;
         default: idx = lo;
      endcase
      return idx;
   endfunction

   // Left rotate amount of a round.
   function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
      logic [4:0] amt;
      case ({rnd[5:4], rnd[1:0]})
         4'h0:    amt = 5'd7;
         4'h1:    amt = 5'd12;
         4'h2:    amt = 5'd17;
         4'h3:    amt = 5'd22;
         4'h4:    amt = 5'd5;
         4'h5:    amt = 5'd9;
         4'h6:    amt = 5'd14;
         4'h7:    amt = 5'd20;
         4'h8:    amt = 5'd4;
         4'h9:    amt = 5'd11;
         4'hA:    amt = 5'd16;
         4'hB:    amt = 5'd23;
         4'hC:    amt = 5'd6;
         4'hD:    amt = 5'd10;
         4'hE:    amt = 5'd15;
         4'hF:    amt = 5'd21;
         default: amt = 5'd0;
      endcase
      return amt;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] dbl;
      dbl = {v, v} << n;
      return dbl[63:32];
   endfunction

endpackage

// ===== sv/md5sh_block_buffer.sv =====
// ----------------------------------------------------------------------------
// md5sh_block_buffer
// Sixteen-word message block with byte-granular packing, padding and length.
// ----------------------------------------------------------------------------
module md5sh_block_buffer (
   input  logic                    clock,
   input  md5sh_pkg::buf_ctrl_type bctl,
   input  logic [3:0]              rd_idx,
   output logic [31:0]             rd_word
);
   import md5sh_pkg::*;

   logic [31:0] blk_ff [16];
   logic [31:0] blk_in [16];

   // Each byte lane decides on its own whether this cycle writes it.
   always_comb begin
      logic [5:0] pos;
      logic [5:0] off;
      logic [7:0] byte_val;
      logic       we;
      for (int w = 0; w < 16; w++) begin
         blk_in[w] = blk_ff[w];
         for (int b = 0; b < 4; b++) begin
            pos = 6'(w * 4 + b);
            off = pos - bctl.fill;
            we = 1'b0;
            byte_val = 8'h00;
            case (bctl.op)
               BUF_DATA: begin
                  we = off < {3'b000, bctl.cnt};
                  byte_val = bctl.data[{off[1:0], 3'b000} +: 8];
               end
               BUF_PAD: begin
                  we = pos >= bctl.fill;
                  byte_val = (pos == bctl.fill) ? 8'h80 : 8'h00;
               end
               BUF_CLEAR: begin
                  we = 1'b1;
               end
               default: begin
                  we = 1'b0;
               end
            endcase
            if ((bctl.op == BUF_PAD || bctl.op == BUF_CLEAR) && bctl.len_en &&
                pos >= LEN_POS) begin
               we = 1'b1;
               byte_val = bctl.len_bits[{pos[2:0], 3'b000} +: 8];
            end
            if (we) begin
               blk_in[w][b*8 +: 8] = byte_val;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

   assign rd_word = blk_ff[rd_idx];

endmodule

// ===== sv/md5sh_round_unit.sv =====
// ----------------------------------------------------------------------------
// md5sh_round_unit
// Shared MD5 step datapath with working and chaining registers.
// ----------------------------------------------------------------------------
module md5sh_round_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  md5sh_pkg::rnd_ctrl_type rctl,
   input  logic [31:0]             w_word,
   output md5sh_pkg::word4_type    chain
);
   import md5sh_pkg::*;

   word4_type   chain_ff, chain_in;
   word4_type   work_ff, work_in;
   logic [31:0] kw_ff, kw_in;

   logic [31:0] a, b, c, d, f, sum, newb;

   always_comb begin
      a = work_ff[0];
      b = work_ff[1];
      c = work_ff[2];
      d = work_ff[3];
      case (rctl.rnd[5:4])
         2'd0:    f = (b & c) | (~b & d);
         2'd1:    f = (b & d) | (c & ~d);
         2'd2:    f = b ^ c ^ d;
         2'd3:    f = c ^ (b | ~d);
         default: f = '0;
      endcase
      // The constant and message word were summed in the cycle before and registered in kw_ff.
      sum = a + f + kw_ff;
      newb = b + rotl32(sum, rot_amount(rctl.rnd));
   end

   always_comb begin
      work_in = work_ff;
      if (rctl.load) begin
         work_in = chain_ff;
      end else if (rctl.run) begin
         work_in = {c, b, newb, d};
      end
      chain_in = chain_ff;
      if (rctl.init) begin
         chain_in = CHAIN_INIT;
      end else if (rctl.accum) begin
         for (int i = 0; i < 4; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      kw_in = K_TABLE[rctl.kw_rnd] + w_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= CHAIN_INIT;
      end else begin
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      kw_ff <= kw_in;
   end

   assign chain = chain_ff;

endmodule

// ===== sv/md5_stream_hasher_core.sv =====
// ----------------------------------------------------------------------------
// md5_stream_hasher_core
// MD5 digest of a byte message delivered as little-endian 32-bit words.
// ----------------------------------------------------------------------------
// A word that does not complete a block keeps busy high only while it is packed.
// A word that completes a 64-byte block adds a compression (load, 64 steps, add)
// and a repack of its rest. A final word adds a padding step and a compression of
// the padded block, one more if the length spills into a clear block; four digest
// words then follow back to back. Busy blocks new words; results are never held off.
// Reset is synchronous; it restores the MD5 initial chain and clears all counts.
// ----------------------------------------------------------------------------
module md5_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_msg_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_final_word,
   output logic        rsp_strobe,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_result
);
   import md5sh_pkg::*;

   // The sequencer walks an item through packing, optional compression,
   // padding and the digest readout.  Compression always returns to the
   // state recorded in after_ff.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_PAD,
      ST_CLEAR,
      ST_CMP_LOAD,
      ST_CMP_RUN,
      ST_CMP_ADD,
      ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   state_type   after_ff, after_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [1:0]  emit_idx_ff, emit_idx_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] total_ff, total_in;
   logic [31:0] pend_word_ff, pend_word_in;
   logic [2:0]  pend_cnt_ff, pend_cnt_in;
   logic        pend_fin_ff, pend_fin_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   logic [31:0] rsp_digest_word_ff, rsp_digest_word_in;
   logic [1:0]  rsp_word_index_ff, rsp_word_index_in;
   logic        rsp_last_result_ff, rsp_last_result_in;

   buf_ctrl_type bctl;
   rnd_ctrl_type rctl;
   word4_type    chain;
   logic [31:0]  w_word;
   logic [2:0]   req_cnt;
   logic [6:0]   room;
   logic [2:0]   take;
   logic [6:0]   fill_sum;

   // Byte counts above four are treated as four.
   assign req_cnt = (req_byte_count > MAX_BYTES) ? MAX_BYTES : req_byte_count;

   // A pending word is split where it would run past the end of the block:
   // the bytes that fit are written, the block is compressed, and the rest
   // is packed afterwards at the start of the next block.
   assign room = 7'd64 - {1'b0, fill_ff};
   assign take = ({4'b0000, pend_cnt_ff} < room) ? pend_cnt_ff : room[2:0];
   assign fill_sum = {1'b0, fill_ff} + {4'b0000, take};

   always_comb begin
      state_in = state_ff;
      after_in = after_ff;
      rnd_in = rnd_ff;
      emit_idx_in = emit_idx_ff;
      fill_in = fill_ff;
      total_in = total_ff;
      pend_word_in = pend_word_ff;
      pend_cnt_in = pend_cnt_ff;
      pend_fin_in = pend_fin_ff;
      rsp_strobe_in = 1'b0;
      rsp_digest_word_in = rsp_digest_word_ff;
      rsp_word_index_in = rsp_word_index_ff;
      rsp_last_result_in = rsp_last_result_ff;

      bctl.op = BUF_IDLE;
      bctl.fill = fill_ff;
      bctl.cnt = take;
      bctl.data = pend_word_ff;
      bctl.len_en = 1'b0;
      bctl.len_bits = {total_ff, 3'b000};

      rctl.load = 1'b0;
      rctl.run = 1'b0;
      rctl.accum = 1'b0;
      rctl.init = 1'b0;
      rctl.rnd = rnd_ff;
      rctl.kw_rnd = rnd_ff + 6'd1;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pend_word_in = req_msg_word;
               pend_cnt_in = req_cnt;
               pend_fin_in = req_final_word;
               total_in = total_ff + {58'd0, req_cnt};
               state_in = ST_ABSORB;
            end
         end
         ST_ABSORB: begin
            bctl.op = BUF_DATA;
            pend_word_in = pend_word_ff >> {take, 3'b000};
            pend_cnt_in = pend_cnt_ff - take;
            if (fill_sum[6]) begin
               fill_in = '0;
               after_in = ST_ABSORB;
               state_in = ST_CMP_LOAD;
            end else begin
               fill_in = fill_sum[5:0];
               state_in = pend_fin_ff ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            // The length fits behind the 0x80 marker only when the marker
            // lands before byte 56; otherwise a second block carries it.
            bctl.op = BUF_PAD;
            bctl.len_en = fill_ff < LEN_POS;
            after_in = (fill_ff < LEN_POS) ? ST_EMIT : ST_CLEAR;
            state_in = ST_CMP_LOAD;
         end
         ST_CLEAR: begin
            bctl.op = BUF_CLEAR;
            bctl.len_en = 1'b1;
            after_in = ST_EMIT;
            state_in = ST_CMP_LOAD;
         end
         ST_CMP_LOAD: begin
            rctl.load = 1'b1;
            rctl.kw_rnd = '0;
            rnd_in = '0;
            state_in = ST_CMP_RUN;
         end
         ST_CMP_RUN: begin
            rctl.run = 1'b1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_CMP_ADD;
            end
         end
         ST_CMP_ADD: begin
            rctl.accum = 1'b1;
            emit_idx_in = '0;
            state_in = after_ff;
         end
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_digest_word_in = chain[emit_idx_ff];
            rsp_word_index_in = emit_idx_ff;
            rsp_last_result_in = emit_idx_ff == 2'd3;
            emit_idx_in = emit_idx_ff + 2'd1;
            if (emit_idx_ff == 2'd3) begin
               // The last digest word is captured on this same edge, so the
               // chain can return to the initial values for the next message.
               rctl.init = 1'b1;
               fill_in = '0;
               total_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         after_ff <= ST_IDLE;
         rnd_ff <= '0;
         emit_idx_ff <= '0;
         fill_ff <= '0;
         total_ff <= '0;
         pend_cnt_ff <= '0;
         pend_fin_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         rnd_ff <= rnd_in;
         emit_idx_ff <= emit_idx_in;
         fill_ff <= fill_in;
         total_ff <= total_in;
         pend_cnt_ff <= pend_cnt_in;
         pend_fin_ff <= pend_fin_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      pend_word_ff <= pend_word_in;
      rsp_digest_word_ff <= rsp_digest_word_in;
      rsp_word_index_ff <= rsp_word_index_in;
      rsp_last_result_ff <= rsp_last_result_in;
   end

   // The buffer is read for the next round so the constant can be added early.
   md5sh_block_buffer u_block_buffer (
      .clock   (clock),
      .bctl    (bctl),
      .rd_idx  (msg_index(rctl.kw_rnd)),
      .rd_word (w_word)
   );

   md5sh_round_unit u_round_unit (
      .clock  (clock),
      .reset  (reset),
      .rctl   (rctl),
      .w_word (w_word),
      .chain  (chain)
   );

   assign busy = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_digest_word = rsp_digest_word_ff;
   assign rsp_word_index = rsp_word_index_ff;
   assign rsp_last_result = rsp_last_result_ff;

endmodule

// ===== sv/md5sh_checker.sv =====
// ----------------------------------------------------------------------------
// md5sh_checker
// Port-level checks of the MD5 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
`include "md5_stream_hasher_core_assert.svh"

module md5sh_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_word_index,
   input logic        rsp_last_result
);

   // Every accepted item makes the block busy in the following cycle.
   `MD5SH_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // Digest words come out back to back in order A, B, C, D.
   `MD5SH_ASSERT_NEXT(a_digest_order, clock, reset,
      rsp_strobe && rsp_word_index != 2'd3,
      rsp_strobe && rsp_word_index == $past(rsp_word_index) + 2'd1)

   // The last flag marks exactly the fourth digest word.
   `MD5SH_ASSERT_IMPL(a_last_flag, clock, reset, rsp_strobe,
      rsp_last_result == (rsp_word_index == 2'd3))

   // No new item is taken while the digest is still being read out.
   `MD5SH_ASSERT_IMPL(a_busy_emit, clock, reset, rsp_strobe && !rsp_last_result, busy)

endmodule

bind md5_stream_hasher_core md5sh_checker u_md5sh_checker (.*);
